>>> hdl/iwy_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iwy_pkg
// Constants and small arithmetic helpers for the ISO week date pipeline.
// ----------------------------------------------------------------------------
package iwy_pkg;

    localparam int NUM_STAGES = 6;

    // A multiple of 400 that makes every 20-bit year non-negative
    localparam logic [20:0] YEAR_BIAS     = 21'd524400;
    // ceil(2^24 / 25): exact floor division by 25 for values below 74565
    localparam logic [19:0] RECIP25       = 20'd671089;
    localparam int          RECIP25_SHIFT = 24;
    // ceil(2^14 / 7): exact floor division by 7 for values below 780
    localparam logic [11:0] RECIP7        = 12'd2341;
    localparam int          RECIP7_SHIFT  = 14;

    localparam logic [2:0] WD_FRIDAY   = 3'd5;
    localparam logic [2:0] WD_SATURDAY = 3'd6;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_MAR = 4'd3;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [5:0] WEEK_FIRST  = 6'd1;
    localparam logic [5:0] WEEK_LONG   = 6'd53;
    localparam logic [5:0] WEEK_SHORT  = 6'd52;

    // Days before the first of each month, common year (index 0 is January)
    function automatic logic [8:0] month_start(input logic [3:0] idx);
        logic [8:0] res;
        case (idx)
            4'd0:    res = 9'd0;
            4'd1:    res = 9'd31;
            4'd2:    res = 9'd59;
            4'd3:    res = 9'd90;
            4'd4:    res = 9'd120;
            4'd5:    res = 9'd151;
            4'd6:    res = 9'd181;
            4'd7:    res = 9'd212;
            4'd8:    res = 9'd243;
            4'd9:    res = 9'd273;
            4'd10:   res = 9'd304;
            4'd11:   res = 9'd334;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] idx);
        logic [4:0] res;
        case (idx)
            4'd1:                      res = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   res = 5'd30;
            default:                   res = 5'd31;
        endcase
        return res;
    endfunction

    // Leap test on the year taken modulo 400
    function automatic logic is_leap400(input logic [8:0] r);
        return (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
    endfunction

    // Modulo 7 by folding octal digits (8 is 1 modulo 7)
    function automatic logic [2:0] mod7(input logic [9:0] x);
        logic [4:0] s1;
        logic [3:0] s2;
        s1 = 5'(x[9]) + 5'(x[8:6]) + 5'(x[5:3]) + 5'(x[2:0]);
        s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
        return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
    endfunction

endpackage
`default_nettype wire

>>> hdl/iwy_pipe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iwy_pipe_ctrl
// Valid tracking and per-stage load enables for an elastic pipeline; a stage
// loads whenever it is empty or the stage after it moves on.
// ----------------------------------------------------------------------------
module iwy_pipe_ctrl #(
    parameter int STAGES = iwy_pkg::NUM_STAGES
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [STAGES-1:0]      stage_en
);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES:0]   rdy;

    always_comb
    begin
        rdy[STAGES] = out_ready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
        valid_next[0] = rdy[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            valid_next[k] = rdy[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign stage_en  = rdy[STAGES-1:0];
    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[STAGES-1];

endmodule
`default_nettype wire

>>> hdl/iso_week_of_year.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iso_week_of_year
// ISO 8601 week date of a proleptic Gregorian date, six-stage pipeline.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_ready  | year, month, day
//   out     | out_valid / out_ready| week_number, week_year, weekday,
//           |                      | ordinal_day
//
// One date enters per cycle while in_ready is high; its result passes
// through every stage register. The depth is set by the reciprocal multiplier
// for the year modulo 400 and by the one for the week division, each
// followed by a stage. Reset clears only the valid bits. A stall at the
// output fills empty stages and then holds every stage in place.
// ----------------------------------------------------------------------------
module iso_week_of_year (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [19:0] year,
    input  wire logic [3:0]  month,
    input  wire logic [4:0]  day,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [5:0]       week_number,
    output logic [19:0]      week_year,
    output logic [2:0]       weekday,
    output logic [8:0]       ordinal_day
);
    import iwy_pkg::*;

    logic [NUM_STAGES-1:0] en;

    iwy_pipe_ctrl #(
        .STAGES (NUM_STAGES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stage_en  (en)
    );

    // ---------------- stage 1: bias the year, start divide by 25 ----------
    logic [20:0] ubias;
    logic [19:0] year1_reg,  year1_next;
    logic [3:0]  month1_reg, month1_next;
    logic [4:0]  day1_reg,   day1_next;
    logic [3:0]  lo1_reg,    lo1_next;
    logic [16:0] v1_reg,     v1_next;
    logic [36:0] prod1_reg,  prod1_next;

    always_comb
    begin
        ubias       = {year[19], year} + YEAR_BIAS;
        year1_next  = year;
        if (month < MONTH_JAN)
            month1_next = MONTH_JAN;
        else if (month > MONTH_DEC)
            month1_next = MONTH_DEC;
        else
            month1_next = month;
        day1_next   = (day == 5'd0) ? 5'd1 : day;
        v1_next     = ubias[20:4];
        lo1_next    = ubias[3:0];
        prod1_next  = 37'(v1_next) * 37'(RECIP25);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            year1_reg  <= year1_next;
            month1_reg <= month1_next;
            day1_reg   <= day1_next;
            lo1_reg    <= lo1_next;
            v1_reg     <= v1_next;
            prod1_reg  <= prod1_next;
        end
    end

    // ---------------- stage 2: year modulo 400 ----------------------------
    logic [12:0] q25;
    logic [16:0] rem25;
    logic [19:0] year2_reg,  year2_next;
    logic [3:0]  month2_reg, month2_next;
    logic [4:0]  day2_reg,   day2_next;
    logic [8:0]  r2_reg,     r2_next;

    always_comb
    begin
        q25         = prod1_reg[RECIP25_SHIFT +: 13];
        rem25       = v1_reg - 17'({q25, 4'b0000}) - 17'({q25, 3'b000}) - 17'(q25);
        r2_next     = {rem25[4:0], lo1_reg};
        year2_next  = year1_reg;
        month2_next = month1_reg;
        day2_next   = day1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            year2_reg  <= year2_next;
            month2_reg <= month2_next;
            day2_reg   <= day2_next;
            r2_reg     <= r2_next;
        end
    end

    // ---------------- stage 3: leap flags, ordinal, day count mod 7 -------
    logic        leap3;
    logic [8:0]  rprev;
    logic [3:0]  midx;
    logic [4:0]  mlen;
    logic [4:0]  day_c;
    logic [2:0]  q100;
    logic [9:0]  r31;
    logic [19:0] year3_reg,    year3_next;
    logic [8:0]  ordinal3_reg, ordinal3_next;
    logic [9:0]  dbase3_reg,   dbase3_next;
    logic        leap3_reg,    leap3_next;
    logic        leapp3_reg,   leapp3_next;

    always_comb
    begin
        leap3 = is_leap400(r2_reg);
        rprev = (r2_reg == 9'd0) ? 9'd399 : r2_reg - 9'd1;
        midx  = month2_reg - MONTH_JAN;
        mlen  = month_len(midx) + 5'((midx == 4'd1) && leap3);
        day_c = (day2_reg > mlen) ? mlen : day2_reg;
        if (r2_reg == 9'd0)
            q100 = 3'd0;
        else if (r2_reg <= 9'd100)
            q100 = 3'd1;
        else if (r2_reg <= 9'd200)
            q100 = 3'd2;
        else if (r2_reg <= 9'd300)
            q100 = 3'd3;
        else
            q100 = 3'd4;
        r31 = 10'(r2_reg) + 10'd31;
        // Day count to January 1 modulo 7, over the 400-year cycle
        dbase3_next   = 10'(r2_reg) + 10'd30 + 10'(r31[9:2]) + 10'(r2_reg != 9'd0)
                        + 10'd7 - 10'(q100);
        ordinal3_next = month_start(midx) + 9'(day_c)
                        + 9'(leap3 && (month2_reg >= MONTH_MAR));
        leap3_next    = leap3;
        leapp3_next   = is_leap400(rprev);
        year3_next    = year2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            year3_reg    <= year3_next;
            ordinal3_reg <= ordinal3_next;
            dbase3_reg   <= dbase3_next;
            leap3_reg    <= leap3_next;
            leapp3_reg   <= leapp3_next;
        end
    end

    // ---------------- stage 4: weekday of the date and of January 1 -------
    logic [19:0] year4_reg,    year4_next;
    logic [8:0]  ordinal4_reg, ordinal4_next;
    logic [2:0]  wd4_reg,      wd4_next;
    logic [2:0]  jan14_reg,    jan14_next;
    logic        leap4_reg,    leap4_next;
    logic        leapp4_reg,   leapp4_next;

    always_comb
    begin
        wd4_next      = mod7(dbase3_reg + 10'(ordinal3_reg) + 10'd2) + 3'd1;
        jan14_next    = mod7(dbase3_reg + 10'd3) + 3'd1;
        year4_next    = year3_reg;
        ordinal4_next = ordinal3_reg;
        leap4_next    = leap3_reg;
        leapp4_next   = leapp3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            year4_reg    <= year4_next;
            ordinal4_reg <= ordinal4_next;
            wd4_reg      <= wd4_next;
            jan14_reg    <= jan14_next;
            leap4_reg    <= leap4_next;
            leapp4_reg   <= leapp4_next;
        end
    end

    // ---------------- stage 5: week = (ordinal + 10 - weekday) / 7 --------
    logic [8:0]  wnum;
    logic [19:0] year5_reg,    year5_next;
    logic [8:0]  ordinal5_reg, ordinal5_next;
    logic [2:0]  wd5_reg,      wd5_next;
    logic [2:0]  jan15_reg,    jan15_next;
    logic        leap5_reg,    leap5_next;
    logic        leapp5_reg,   leapp5_next;
    logic [20:0] wprod5_reg,   wprod5_next;

    always_comb
    begin
        wnum          = ordinal4_reg + 9'd10 - 9'(wd4_reg);
        wprod5_next   = 21'(wnum) * 21'(RECIP7);
        year5_next    = year4_reg;
        ordinal5_next = ordinal4_reg;
        wd5_next      = wd4_reg;
        jan15_next    = jan14_reg;
        leap5_next    = leap4_reg;
        leapp5_next   = leapp4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            year5_reg    <= year5_next;
            ordinal5_reg <= ordinal5_next;
            wd5_reg      <= wd5_next;
            jan15_reg    <= jan15_next;
            leap5_reg    <= leap5_next;
            leapp5_reg   <= leapp5_next;
            wprod5_reg   <= wprod5_next;
        end
    end

    // ---------------- stage 6: year-edge weeks, output register -----------
    logic [6:0]  wk_raw;
    logic [8:0]  in_year;
    logic [9:0]  left_sum;
    logic [5:0]  week_number_reg, week_number_next;
    logic [19:0] week_year_reg,   week_year_next;
    logic [2:0]  weekday_reg,     weekday_next;
    logic [8:0]  ordinal_day_reg, ordinal_day_next;

    always_comb
    begin
        wk_raw   = wprod5_reg[RECIP7_SHIFT +: 7];
        in_year  = leap5_reg ? 9'd366 : 9'd365;
        // days left in the year plus weekday: below 4 means no Thursday remains
        left_sum = 10'(in_year - ordinal5_reg) + 10'(wd5_reg);
        week_number_next = wk_raw[5:0];
        week_year_next   = year5_reg;
        if (wk_raw == 7'd0)
        begin
            week_year_next = year5_reg - 20'd1;
            if ((jan15_reg == WD_FRIDAY) || ((jan15_reg == WD_SATURDAY) && leapp5_reg))
                week_number_next = WEEK_LONG;
            else
                week_number_next = WEEK_SHORT;
        end
        else if ((wk_raw == 7'(WEEK_LONG)) && (left_sum < 10'd4))
        begin
            week_number_next = WEEK_FIRST;
            week_year_next   = year5_reg + 20'd1;
        end
        weekday_next     = wd5_reg;
        ordinal_day_next = ordinal5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            week_number_reg <= week_number_next;
            week_year_reg   <= week_year_next;
            weekday_reg     <= weekday_next;
            ordinal_day_reg <= ordinal_day_next;
        end
    end

    assign week_number = week_number_reg;
    assign week_year   = week_year_reg;
    assign weekday     = weekday_reg;
    assign ordinal_day = ordinal_day_reg;

endmodule
`default_nettype wire

>>> hdl/iwy_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iwy_checker
// Port-level checks on the ISO week date block, bound to its top level.
// ----------------------------------------------------------------------------
module iwy_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [5:0]  week_number,
    input wire logic [19:0] week_year,
    input wire logic [2:0]  weekday,
    input wire logic [8:0]  ordinal_day
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(week_number)
            && $stable(week_year) && $stable(weekday) && $stable(ordinal_day))
        else $error("result changed while stalled");

    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> weekday >= 3'd1 && weekday <= 3'd7
            && ordinal_day >= 9'd1 && ordinal_day <= 9'd366)
        else $error("weekday or ordinal day out of range");

    a_mid_year: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ordinal_day >= 9'd11 && ordinal_day <= 9'd357
            |-> week_number >= 6'd2 && week_number <= 6'd52)
        else $error("mid-year date in an edge week");

    a_early_week: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ordinal_day <= 9'd7 && week_number >= 6'd52 |-> weekday >= 3'd5)
        else $error("early date in previous year with wrong weekday");

    a_late_week: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && week_number == 6'd1 && ordinal_day > 9'd11
            |-> ordinal_day >= 9'd362 && weekday <= 3'd3)
        else $error("late date rolled to week one wrongly");

endmodule

bind iso_week_of_year iwy_checker u_iwy_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .week_number (week_number),
    .week_year   (week_year),
    .weekday     (weekday),
    .ordinal_day (ordinal_day)
);
`default_nettype wire
